// File: src/stq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timer event queue package
// Shared types, result codes and defaults for the timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int unsigned DefDepth    = 16;
  localparam int unsigned DefTimeBits = 48;
  localparam int unsigned DefTagBits  = 16;
  localparam int unsigned CmdBits     = 2;
  localparam int unsigned DelayBits   = 32;
  localparam int unsigned HandleBits  = 4;
  localparam int unsigned KindBits    = 3;

  typedef enum logic [CmdBits-1:0] {
    CMD_RUN     = 2'd0,
    CMD_SET_REL = 2'd1,
    CMD_SET_ABS = 2'd2,
    CMD_CANCEL  = 2'd3
  } cmd_t;

  typedef enum logic [KindBits-1:0] {
    KIND_SET_OK    = 3'd0,
    KIND_SET_FULL  = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_FIRED     = 3'd4,
    KIND_WAIT      = 3'd5,
    KIND_EMPTY     = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RUN,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input word
    logic exec;    // perform a set or cancel and emit its result
    logic pop;     // emit the head as fired and remove it
    logic finish;  // emit wait or empty, last
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_run;
    logic head_expired;
  } ctl_sts_t;

endpackage

// File: src/stq_ctrl.sv
// ----------------------------------------------------------------------------
// Timer queue controller
// Sequences one command word through load, execute and the run pop loop.
// ----------------------------------------------------------------------------
module stq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  stq_pkg::ctl_sts_t sts,
  output stq_pkg::ctl_cmd_t cmd
);
  import stq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.is_run) state_nxt = ST_RUN;
        else state_nxt = ST_IDLE;
      end
      ST_RUN: begin
        if (!sts.head_expired) state_nxt = ST_DONE;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_EXEC: cmd.exec = !sts.is_run;
      ST_RUN:  cmd.pop = sts.head_expired;
      ST_DONE: cmd.finish = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

// File: src/stq_datapath.sv
// ----------------------------------------------------------------------------
// Timer queue datapath
// Sorted slot registers with shift insert and remove, handle map and result
// register.
// ----------------------------------------------------------------------------
module stq_datapath #(
  parameter int unsigned DEPTH     = stq_pkg::DefDepth,
  parameter int unsigned TIME_BITS = stq_pkg::DefTimeBits,
  parameter int unsigned TAG_BITS  = stq_pkg::DefTagBits
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  stq_pkg::ctl_cmd_t               cmd,
  output stq_pkg::ctl_sts_t               sts,
  input  logic [stq_pkg::CmdBits-1:0]     in_command,
  input  logic [TIME_BITS-1:0]            in_now_us,
  input  logic [stq_pkg::DelayBits-1:0]   in_delay_us,
  input  logic [TIME_BITS-1:0]            in_deadline_us,
  input  logic [TAG_BITS-1:0]             in_tag,
  input  logic [stq_pkg::HandleBits-1:0]  in_handle,
  output logic                            out_valid,
  output logic [stq_pkg::KindBits-1:0]    out_kind,
  output logic [stq_pkg::HandleBits-1:0]  out_handle,
  output logic [TAG_BITS-1:0]             out_tag,
  output logic [TIME_BITS-1:0]            out_wait_us,
  output logic                            out_last
);
  import stq_pkg::*;

  localparam int unsigned IdxBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);

  logic [TIME_BITS-1:0]  dl_r [DEPTH];
  logic [TAG_BITS-1:0]   tg_r [DEPTH];
  logic [IdxBits-1:0]    hd_r [DEPTH];
  logic [DEPTH-1:0]      busy_r;
  logic [CntBits-1:0]    cnt_r;

  logic [CmdBits-1:0]    cmd_r;
  logic [TIME_BITS-1:0]  now_r;
  logic [TIME_BITS-1:0]  key_r;
  logic [TAG_BITS-1:0]   tag_r;
  logic [HandleBits-1:0] hin_r;

  logic                  ov_r;
  logic [KindBits-1:0]   kind_r;
  logic [HandleBits-1:0] ho_r;
  logic [TAG_BITS-1:0]   to_r;
  logic [TIME_BITS-1:0]  wo_r;
  logic                  last_r;

  logic [TIME_BITS:0]    rel_sum;
  logic [TIME_BITS-1:0]  key_nxt;
  logic [DEPTH-1:0]      le_vec;
  logic [DEPTH-1:0]      hit_vec;
  logic [DEPTH-1:0]      free_vec;
  logic [IdxBits-1:0]    free_idx;
  logic                  free_any;
  logic                  full;
  logic                  can_ok;
  logic                  head_exp;
  logic                  do_ins;
  logic                  do_rem;
  logic [DEPTH-1:0]      rem_vec;

  assign rel_sum = {1'b0, in_now_us} + TIME_BITS'(in_delay_us);
  assign key_nxt = (in_command == CMD_SET_REL) ?
                   (rel_sum[TIME_BITS] ? '1 : rel_sum[TIME_BITS-1:0]) : in_deadline_us;

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    free_vec = ~busy_r;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_idx = IdxBits'(i);
        free_any = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le_vec[i]  = (CntBits'(i) < cnt_r) && (dl_r[i] <= key_r);
      hit_vec[i] = (CntBits'(i) < cnt_r) && (HandleBits'(hd_r[i]) == hin_r);
    end
  end

  assign full     = (cnt_r >= CntBits'(DEPTH)) || !free_any;
  assign can_ok   = (32'(hin_r) < DEPTH) && (|hit_vec);
  assign head_exp = (cnt_r != '0) && (dl_r[0] < now_r);
  assign do_ins   = cmd.exec && (cmd_r != CMD_CANCEL) && !full;
  assign do_rem   = (cmd.exec && (cmd_r == CMD_CANCEL) && can_ok) || cmd.pop;

  // Slots at and beyond the removed one, all but the last, take their upper neighbour.
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      seen = seen | (cmd.pop ? (i == 0) : hit_vec[i]);
      rem_vec[i] = seen;
    end
  end

  assign sts.is_run       = (cmd_r == CMD_RUN);
  assign sts.head_expired = head_exp;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      now_r <= in_now_us;
      key_r <= key_nxt;
      tag_r <= in_tag;
      hin_r <= in_handle;
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (do_ins) begin
        if (!le_vec[i]) begin
          if (i == 0 || le_vec[(i == 0) ? 0 : i - 1]) begin
            dl_r[i] <= key_r;
            tg_r[i] <= tag_r;
            hd_r[i] <= free_idx;
          end else begin
            dl_r[i] <= dl_r[(i == 0) ? 0 : i - 1];
            tg_r[i] <= tg_r[(i == 0) ? 0 : i - 1];
            hd_r[i] <= hd_r[(i == 0) ? 0 : i - 1];
          end
        end
      end else if (do_rem && rem_vec[i] && i + 1 < DEPTH) begin
        dl_r[i] <= dl_r[(i + 1 < DEPTH) ? i + 1 : i];
        tg_r[i] <= tg_r[(i + 1 < DEPTH) ? i + 1 : i];
        hd_r[i] <= hd_r[(i + 1 < DEPTH) ? i + 1 : i];
      end
    end
    ho_r <= '0;
    to_r <= '0;
    wo_r <= '0;
    kind_r <= KIND_EMPTY;
    if (cmd.exec) begin
      if (cmd_r == CMD_CANCEL) begin
        kind_r <= can_ok ? KIND_CANCELLED : KIND_NOT_FOUND;
        ho_r   <= hin_r;
      end else if (full) begin
        kind_r <= KIND_SET_FULL;
      end else begin
        kind_r <= KIND_SET_OK;
        ho_r   <= HandleBits'(free_idx);
      end
    end else if (cmd.pop) begin
      kind_r <= KIND_FIRED;
      ho_r   <= HandleBits'(hd_r[0]);
      to_r   <= tg_r[0];
    end else if (cmd.finish && cnt_r != '0) begin
      kind_r <= KIND_WAIT;
      wo_r   <= dl_r[0] - now_r;
    end
    last_r <= cmd.exec || cmd.finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      ov_r <= cmd.exec || cmd.pop || cmd.finish;
      if (do_ins) begin
        busy_r[free_idx] <= 1'b1;
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rem) begin
        busy_r[cmd.pop ? hd_r[0] : IdxBits'(hin_r)] <= 1'b0;
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign out_valid   = ov_r;
  assign out_kind    = kind_r;
  assign out_handle  = ho_r;
  assign out_tag     = to_r;
  assign out_wait_us = wo_r;
  assign out_last    = last_r;

endmodule

// File: src/sorted_timer_event_queue.sv
// ----------------------------------------------------------------------------
// Sorted timer event queue
// Holds pending timers sorted by deadline; sets, cancels and fires them.
//
//   channel  handshake          payload
//   input    start / busy       in_command, in_now_us, in_delay_us,
//                               in_deadline_us, in_tag, in_handle
//   result   out_valid strobe   out_kind, out_handle, out_tag, out_wait_us,
//                               out_last
//
// A set or cancel word passes through the execute state and back to idle.
// A run word passes through execute, the pop loop and done; the pop loop in the
// controller removes one head slot a cycle.
// Reset clears the count and handle map; slot contents need no reset.
// The receiver cannot stall: each result shows for one cycle only.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue #(
  parameter int unsigned DEPTH     = stq_pkg::DefDepth,
  parameter int unsigned TIME_BITS = stq_pkg::DefTimeBits,
  parameter int unsigned TAG_BITS  = stq_pkg::DefTagBits
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [stq_pkg::CmdBits-1:0]     in_command,
  input  logic [TIME_BITS-1:0]            in_now_us,
  input  logic [stq_pkg::DelayBits-1:0]   in_delay_us,
  input  logic [TIME_BITS-1:0]            in_deadline_us,
  input  logic [TAG_BITS-1:0]             in_tag,
  input  logic [stq_pkg::HandleBits-1:0]  in_handle,
  output logic                            out_valid,
  output logic [stq_pkg::KindBits-1:0]    out_kind,
  output logic [stq_pkg::HandleBits-1:0]  out_handle,
  output logic [TAG_BITS-1:0]             out_tag,
  output logic [TIME_BITS-1:0]            out_wait_us,
  output logic                            out_last
);
  import stq_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  stq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  stq_datapath #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS),
    .TAG_BITS  (TAG_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_command     (in_command),
    .in_now_us      (in_now_us),
    .in_delay_us    (in_delay_us),
    .in_deadline_us (in_deadline_us),
    .in_tag         (in_tag),
    .in_handle      (in_handle),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_handle     (out_handle),
    .out_tag        (out_tag),
    .out_wait_us    (out_wait_us),
    .out_last       (out_last)
  );

endmodule
